// ===== rtl/narm_pkg.sv =====
// Package for the node address range map: field widths, command, type and
// status codes, item structs and the controller/datapath interface structs.
// No dependencies.
package narm_pkg;

  // Fixed field widths
  localparam int ADDR_W   = 48;
  localparam int NODE_W   = 4;
  localparam int CMD_W    = 2;
  localparam int TYPE_W   = 2;
  localparam int TARGET_W = 16;
  localparam int STATUS_W = 3;

  // Parameter defaults
  localparam int MAX_REGIONS_DEF = 32;
  localparam int NODE_COUNT_DEF  = 16;
  localparam int PAGE_BITS_DEF   = 12;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Region type codes
  localparam logic [TYPE_W-1:0] TYPE_LOCAL  = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_POOL   = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_REMOTE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISALIGN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [NODE_W-1:0]   node;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   region_size;
    logic [TYPE_W-1:0]   region_type;
    logic [TARGET_W-1:0] region_target;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   hit_start;
    logic [ADDR_W-1:0]   hit_size;
    logic [TYPE_W-1:0]   hit_type;
    logic [TARGET_W-1:0] hit_target;
    logic [ADDR_W-1:0]   pool_base;
  } out_item_t;

  // One stored region
  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [ADDR_W-1:0]   start;
    logic [ADDR_W-1:0]   size;
    logic [TYPE_W-1:0]   rtype;
    logic [TARGET_W-1:0] target;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the accepted item
    logic do_clear;   // empty the table and answer done
    logic do_add;     // check and store a region, answer
    logic do_ack;     // answer done, no change
    logic scan_init;  // rewind the scan index and pool sum
    logic scan_run;   // read one slot per cycle and evaluate it
    logic sum_pass;   // evaluate for the pool sum instead of best match
    logic finish;     // present the lookup answer
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;  // every filled slot read and evaluated
    logic hit;        // best match covers the address
  } ctrl_sts_t;

endpackage

// ===== rtl/narm_ctrl.sv =====
// Controller of the node address range map: sequences clear, add and the
// two table scans of a lookup. Depends on narm_pkg.
module narm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [narm_pkg::CMD_W-1:0]    op,
  input  narm_pkg::ctrl_sts_t           sts,
  output logic                          busy,
  output narm_pkg::ctrl_cmd_t           cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BEST = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Decode state and status into commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (op)
            narm_pkg::CMD_CLEAR: cmd.do_clear = 1'b1;
            narm_pkg::CMD_ADD:   cmd.do_add   = 1'b1;
            narm_pkg::CMD_LOOKUP: begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_BEST;
            end
            default: cmd.do_ack = 1'b1;
          endcase
        end
      end
      S_BEST: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.hit) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SUM;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_SUM: begin
        cmd.scan_run = 1'b1;
        cmd.sum_pass = 1'b1;
        if (sts.scan_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/narm_dpath.sv =====
// Datapath of the node address range map: region memory, fill count, scan
// read port, best match and pool sum registers, result register.
// Depends on narm_pkg.
module narm_dpath #(
  parameter int MAX_REGIONS = narm_pkg::MAX_REGIONS_DEF,
  parameter int NODE_COUNT  = narm_pkg::NODE_COUNT_DEF,
  parameter int PAGE_BITS   = narm_pkg::PAGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  narm_pkg::in_item_t    in_item,
  input  narm_pkg::ctrl_cmd_t   cmd,
  output narm_pkg::ctrl_sts_t   sts,
  output logic                  out_valid,
  output narm_pkg::out_item_t   out_item
);

  localparam int AW    = narm_pkg::ADDR_W;
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [63:0]   PAGE_MASK_W = (64'd1 << PAGE_BITS) - 64'd1;
  localparam logic [AW-1:0] PAGE_MASK   = PAGE_MASK_W[AW-1:0];
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_REGIONS);

  narm_pkg::entry_t mem [MAX_REGIONS];

  narm_pkg::in_item_t  req_r;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  narm_pkg::entry_t    rd_r;
  logic                rd_vld_r, rd_vld_nxt;
  logic                found_r, found_nxt;
  narm_pkg::entry_t    best_r, best_nxt;
  logic [AW-1:0]       sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  narm_pkg::out_item_t out_r, out_nxt;

  logic                misaligned;
  logic                full;
  logic                node_ok;
  logic                add_we;
  narm_pkg::entry_t    new_entry;
  logic                issue;
  logic                rd_match;
  logic                best_take;
  logic                sum_take;
  logic                hit;
  logic [AW:0]         sum_ext;

  // Add checks on the incoming item
  always_comb begin
    misaligned = (|(in_item.address & PAGE_MASK)) || (|(in_item.region_size & PAGE_MASK));
    full       = (fill_r >= FULL_CNT);
    node_ok    = (32'(in_item.node) < NODE_COUNT);
    add_we     = cmd.do_add && !misaligned && !full && node_ok;
    new_entry.node   = in_item.node;
    new_entry.start  = in_item.address;
    new_entry.size   = in_item.region_size;
    new_entry.rtype  = (in_item.region_type == narm_pkg::TYPE_LOCAL ||
                        in_item.region_type == narm_pkg::TYPE_POOL)
                       ? in_item.region_type : narm_pkg::TYPE_REMOTE;
    new_entry.target = in_item.region_target;
  end

  // Write a new region at the fill position
  always_ff @(posedge clk) begin
    if (add_we) begin
      mem[fill_r[IDX_W-1:0]] <= new_entry;
    end
  end

  // Read one slot per scan cycle
  assign issue = cmd.scan_run && (idx_r < fill_r);

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  // Evaluate the slot read in the previous cycle
  always_comb begin
    rd_match  = rd_vld_r && (rd_r.node == req_r.node);
    best_take = rd_match && !cmd.sum_pass && (rd_r.start <= req_r.address) &&
                (!found_r || (rd_r.start >= best_r.start));
    sum_take  = rd_match && cmd.sum_pass && (rd_r.rtype == narm_pkg::TYPE_POOL) &&
                (rd_r.start < best_r.start);
    hit       = found_r && ((req_r.address - best_r.start) < best_r.size);
    sum_ext   = {1'b0, sum_r} + {1'b0, rd_r.size};
  end

  assign sts.scan_done = (idx_r >= fill_r) && !rd_vld_r;
  assign sts.hit       = hit;

  // Next state of fill count, scan and match registers
  always_comb begin
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = issue;
    found_nxt  = found_r;
    best_nxt   = best_r;
    sum_nxt    = sum_r;

    if (cmd.do_clear) begin
      fill_nxt = '0;
    end else if (add_we) begin
      fill_nxt = fill_r + 1'b1;
    end

    if (cmd.load) begin
      found_nxt = 1'b0;
    end else if (best_take) begin
      found_nxt = 1'b1;
      best_nxt  = rd_r;
    end

    priority if (cmd.scan_init) begin
      idx_nxt    = '0;
      rd_vld_nxt = 1'b0;
      sum_nxt    = '0;
    end else if (issue) begin
      idx_nxt = idx_r + 1'b1;
    end

    // Saturate the pool sum at all ones
    if (!cmd.scan_init && sum_take) begin
      sum_nxt = sum_ext[AW] ? '1 : sum_ext[AW-1:0];
    end
  end

  // Build the result item
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    priority if (cmd.do_clear || cmd.do_ack) begin
      out_valid_nxt  = 1'b1;
      out_nxt.status = narm_pkg::ST_DONE;
    end else if (cmd.do_add) begin
      out_valid_nxt = 1'b1;
      if (misaligned) begin
        out_nxt.status = narm_pkg::ST_MISALIGN;
      end else if (full) begin
        out_nxt.status = narm_pkg::ST_FULL;
      end else begin
        out_nxt.status = narm_pkg::ST_DONE;
      end
    end else if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (hit) begin
        out_nxt.status     = narm_pkg::ST_HIT;
        out_nxt.hit_start  = best_r.start;
        out_nxt.hit_size   = best_r.size;
        out_nxt.hit_type   = best_r.rtype;
        out_nxt.hit_target = best_r.target;
        out_nxt.pool_base  = sum_r;
      end else begin
        out_nxt.status = narm_pkg::ST_MISS;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    best_r <= best_nxt;
    sum_r  <= sum_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/node_address_range_map_unit.sv =====
// Top level of the node address range map: per-node region table with
// clear, add and lookup commands. Depends on narm_pkg, narm_ctrl, narm_dpath.
//
// Usage:
//   Command channel: present in_item and raise start; the item is taken at
//   a rising edge with start high and busy low.
//   Result channel: each item gives exactly one result, shown on out_item
//   for one cycle with out_valid high. The receiver cannot stall it.
// Throughput and scans:
//   Clear, add and the unused command answer in the cycle after acceptance
//   and busy stays low, so one of them can be taken every cycle.
//   A lookup reads the region memory through its single read port, one
//   slot per cycle. The best-match scan reads every stored region, weighs
//   the last read and then decides (an empty table goes straight to the
//   decision); on a hit a second scan sums the sizes of the node's pool
//   regions that start below the hit region. Busy stays high through both
//   scans, and the result shows in the cycle busy drops low again.
// Reset:
//   rst_n (synchronous, active low) empties the table and returns to idle;
//   no clearing pass is needed as slots fill in order behind a fill count.
module node_address_range_map_unit #(
  parameter int MAX_REGIONS = narm_pkg::MAX_REGIONS_DEF,
  parameter int NODE_COUNT  = narm_pkg::NODE_COUNT_DEF,
  parameter int PAGE_BITS   = narm_pkg::PAGE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  narm_pkg::in_item_t  in_item,
  output logic                out_valid,
  output narm_pkg::out_item_t out_item
);

  narm_pkg::ctrl_cmd_t ctrl_cmd;
  narm_pkg::ctrl_sts_t ctrl_sts;

  // Sequence commands
  narm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_item.cmd),
    .sts   (ctrl_sts),
    .busy  (busy),
    .cmd   (ctrl_cmd)
  );

  // Table storage and scan
  narm_dpath #(
    .MAX_REGIONS (MAX_REGIONS),
    .NODE_COUNT  (NODE_COUNT),
    .PAGE_BITS   (PAGE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (ctrl_cmd),
    .sts       (ctrl_sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
